[hdl/rvsc_pkg.sv]
// ----------------------------------------------------------------------------
// rvsc_pkg
// Shared widths, types and the result record of the remove-value stream
// compactor.
// ----------------------------------------------------------------------------
package rvsc_pkg;

   // lane count and field widths
   localparam int LANES   = 8;
   localparam int WORD_W  = 32;
   localparam int COUNT_W = 4;
   localparam int FILL_W  = $clog2(LANES);
   localparam int POS_W   = $clog2(2 * LANES);

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [FILL_W-1:0]  fill_type;
   typedef logic [POS_W-1:0]   pos_type;

   // one packed result word as it travels to the output buffer
   typedef struct packed {
      word_type [LANES-1:0] words;
      count_type            count;
      logic                 final_flag;
      word_type             total;
   } result_type;

endpackage

[hdl/rvsc_stream_if.sv]
// ----------------------------------------------------------------------------
// rvsc_req_if / rvsc_rsp_if
// Valid/ready channels carrying input groups and packed result words.
// ----------------------------------------------------------------------------
interface rvsc_req_if;
   import rvsc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] lane_0;
   logic signed [WORD_W-1:0] lane_1;
   logic signed [WORD_W-1:0] lane_2;
   logic signed [WORD_W-1:0] lane_3;
   logic signed [WORD_W-1:0] lane_4;
   logic signed [WORD_W-1:0] lane_5;
   logic signed [WORD_W-1:0] lane_6;
   logic signed [WORD_W-1:0] lane_7;
   logic [COUNT_W-1:0]       valid_lanes;
   logic                     end_of_array;

   modport source (
      output valid, lane_0, lane_1, lane_2, lane_3, lane_4, lane_5, lane_6, lane_7,
             valid_lanes, end_of_array,
      input  ready
   );

   modport sink (
      input  valid, lane_0, lane_1, lane_2, lane_3, lane_4, lane_5, lane_6, lane_7,
             valid_lanes, end_of_array,
      output ready
   );
endinterface

interface rvsc_rsp_if;
   import rvsc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] out_lane_0;
   logic signed [WORD_W-1:0] out_lane_1;
   logic signed [WORD_W-1:0] out_lane_2;
   logic signed [WORD_W-1:0] out_lane_3;
   logic signed [WORD_W-1:0] out_lane_4;
   logic signed [WORD_W-1:0] out_lane_5;
   logic signed [WORD_W-1:0] out_lane_6;
   logic signed [WORD_W-1:0] out_lane_7;
   logic [COUNT_W-1:0]       out_count;
   logic                     final_result;
   logic [WORD_W-1:0]        total_kept;

   modport source (
      output valid, out_lane_0, out_lane_1, out_lane_2, out_lane_3, out_lane_4,
             out_lane_5, out_lane_6, out_lane_7, out_count, final_result, total_kept,
      input  ready
   );

   modport sink (
      input  valid, out_lane_0, out_lane_1, out_lane_2, out_lane_3, out_lane_4,
             out_lane_5, out_lane_6, out_lane_7, out_count, final_result, total_kept,
      output ready
   );
endinterface

[hdl/rvsc_lane.sv]
// ----------------------------------------------------------------------------
// rvsc_lane
// One compare lane: decides whether its word is kept and hands the next
// packing slot on to the following lane.
// ----------------------------------------------------------------------------
module rvsc_lane (
   input  logic              lane_en,
   input  rvsc_pkg::word_type word,
   input  rvsc_pkg::word_type remove_value,
   input  rvsc_pkg::pos_type pos_in,
   output logic              keep,
   output rvsc_pkg::pos_type pos_out
);
   import rvsc_pkg::*;

   // kept when the lane is real and does not match the removed value
   assign keep    = lane_en && (word != remove_value);

   // a kept word lands at pos_in, the next one goes behind it
   assign pos_out = pos_in + pos_type'(keep);

endmodule

[hdl/rvsc_merge.sv]
// ----------------------------------------------------------------------------
// rvsc_merge
// Merging stage: packs kept lane words behind the residual words, emits a
// full word when eight are available and the flush word at end of array.
// ----------------------------------------------------------------------------
module rvsc_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_accept,
   input  logic                               item_end,
   input  rvsc_pkg::word_type [rvsc_pkg::LANES-1:0] lane_words,
   input  logic [rvsc_pkg::LANES-1:0]          lane_keep,
   input  rvsc_pkg::pos_type [rvsc_pkg::LANES-1:0]  lane_pos,
   input  rvsc_pkg::pos_type                  new_fill,
   input  logic                               res_ready,
   output rvsc_pkg::pos_type                  fill,
   output logic                               flush_pending,
   output logic                               res_valid,
   output rvsc_pkg::result_type               res
);
   import rvsc_pkg::*;

   // residual store and counters
   word_type [LANES-1:0] residual_ff;
   word_type [LANES-1:0] residual_in;
   fill_type             residual_count_ff;
   fill_type             residual_count_in;
   word_type             kept_total_ff;
   word_type             kept_total_in;
   logic                 pending_ff;
   logic                 pending_in;

   word_type [2*LANES-1:0] pack_buf;
   word_type [LANES-1:0]   rem_words;
   pos_type                rem_count;
   pos_type                kept;
   logic [WORD_W:0]        total_sum;
   word_type               total_next;
   logic                   full;
   logic                   flush_done;

   assign fill          = pos_type'(residual_count_ff);
   assign flush_pending = pending_ff;

   // packing buffer: residual words first, then kept lane words at their slots
   always_comb begin
      for (int j = 0; j < 2 * LANES; j++) begin
         pack_buf[j] = '0;
         for (int i = 0; i < LANES; i++) begin
            if (lane_keep[i] && (lane_pos[i] == pos_type'(j))) begin
               pack_buf[j] = pack_buf[j] | lane_words[i];
            end
         end
         if ((j < LANES) && (pos_type'(j) < fill)) begin
            pack_buf[j] = residual_ff[j % LANES];
         end
      end
   end

   // split into the full word and the remainder
   assign full      = (new_fill >= pos_type'(LANES));
   assign rem_count = full ? (new_fill - pos_type'(LANES)) : new_fill;

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         rem_words[j] = full ? pack_buf[j + LANES] : pack_buf[j];
      end
   end

   // saturating running total
   assign kept       = new_fill - fill;
   assign total_sum  = {1'b0, kept_total_ff} + (WORD_W + 1)'(kept);
   assign total_next = total_sum[WORD_W] ? '1 : total_sum[WORD_W-1:0];

   // result selection: a pending flush goes first, then the accepted item
   always_comb begin
      res.words      = '0;
      res.count      = '0;
      res.final_flag = 1'b0;
      res.total      = total_next;
      res_valid      = 1'b0;
      if (pending_ff) begin
         res_valid      = 1'b1;
         res.count      = count_type'(residual_count_ff);
         res.final_flag = 1'b1;
         res.total      = kept_total_ff;
         for (int j = 0; j < LANES; j++) begin
            if (fill_type'(j) < residual_count_ff) begin
               res.words[j] = residual_ff[j];
            end
         end
      end else if (item_accept && full) begin
         res_valid = 1'b1;
         res.count = count_type'(LANES);
         for (int j = 0; j < LANES; j++) begin
            res.words[j] = pack_buf[j];
         end
      end else if (item_accept && item_end) begin
         res_valid      = 1'b1;
         res.count      = count_type'(rem_count);
         res.final_flag = 1'b1;
         for (int j = 0; j < LANES; j++) begin
            if (pos_type'(j) < rem_count) begin
               res.words[j] = rem_words[j];
            end
         end
      end
   end

   assign flush_done = pending_ff && res_ready;

   // next state of the counters
   always_comb begin
      residual_count_in = residual_count_ff;
      kept_total_in     = kept_total_ff;
      pending_in        = pending_ff;
      residual_in       = residual_ff;
      if (flush_done) begin
         residual_count_in = '0;
         kept_total_in     = '0;
         pending_in        = 1'b0;
      end else if (item_accept) begin
         residual_in = rem_words;
         if (item_end && !full) begin
            residual_count_in = '0;
            kept_total_in     = '0;
         end else begin
            residual_count_in = fill_type'(rem_count);
            kept_total_in     = total_next;
            pending_in        = item_end;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         residual_count_ff <= '0;
         kept_total_ff     <= '0;
         pending_ff        <= 1'b0;
      end else begin
         residual_count_ff <= residual_count_in;
         kept_total_ff     <= kept_total_in;
         pending_ff        <= pending_in;
      end
   end

   // residual words, no reset needed
   always_ff @(posedge clock) begin
      residual_ff <= residual_in;
   end

endmodule

[hdl/rvsc_out_buf.sv]
// ----------------------------------------------------------------------------
// rvsc_out_buf
// Two-entry output buffer: a head register driving the response channel and
// a skid register that catches a word while the head is stalled.
// ----------------------------------------------------------------------------
module rvsc_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  rvsc_pkg::result_type push_data,
   output logic                 push_ready,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output rvsc_pkg::result_type pop_data
);
   import rvsc_pkg::*;

   logic       head_valid_ff;
   logic       head_valid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type head_ff;
   result_type head_in;
   result_type skid_ff;
   result_type skid_in;
   logic       push;
   logic       pop;

   assign push_ready = !skid_valid_ff;
   assign pop_valid  = head_valid_ff;
   assign pop_data   = head_ff;
   assign push       = push_valid && push_ready;
   assign pop        = head_valid_ff && pop_ready;

   // move words between head and skid
   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            head_valid_in = push;
            head_in       = push_data;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

[hdl/remove_value_stream_compactor.sv]
// ----------------------------------------------------------------------------
// remove_value_stream_compactor
// A result word is registered in the output buffer's head or skid register
// before it appears on rsp. Throughput: one group per cycle while req is not
// stalled; a group that completes a full word and ends the array is followed
// by the flush word. The eight compare lanes and single merge stage set this;
// the two-entry buffer stalls req when rsp backs up, as does a pending flush.
// Reset (synchronous): empties the buffer, clears residual count, running total
// and the removed value; residual words themselves are not cleared.
// ----------------------------------------------------------------------------
module remove_value_stream_compactor (
   input  logic               clock,
   input  logic               reset,
   rvsc_req_if.sink           req_stream,
   rvsc_rsp_if.source         rsp_stream,
   input  logic               csr_wr_en,
   input  rvsc_pkg::word_type csr_wr_data
);
   import rvsc_pkg::*;

   word_type                remove_value_ff;
   word_type [LANES-1:0]    lane_words;
   logic [LANES-1:0]        lane_en;
   logic [LANES-1:0]        lane_keep;
   pos_type [LANES:0]       pos_chain;
   pos_type                 fill;
   logic                    flush_pending;
   logic                    item_accept;
   logic                    res_valid;
   logic                    push_ready;
   result_type              res;
   result_type              head;

   // removed value register
   always_ff @(posedge clock) begin
      if (reset) begin
         remove_value_ff <= '0;
      end else if (csr_wr_en) begin
         remove_value_ff <= csr_wr_data;
      end
   end

   assign lane_words[0] = word_type'(req_stream.lane_0);
   assign lane_words[1] = word_type'(req_stream.lane_1);
   assign lane_words[2] = word_type'(req_stream.lane_2);
   assign lane_words[3] = word_type'(req_stream.lane_3);
   assign lane_words[4] = word_type'(req_stream.lane_4);
   assign lane_words[5] = word_type'(req_stream.lane_5);
   assign lane_words[6] = word_type'(req_stream.lane_6);
   assign lane_words[7] = word_type'(req_stream.lane_7);

   // handshake on the request side
   assign req_stream.ready = !flush_pending && push_ready;
   assign item_accept      = req_stream.valid && req_stream.ready;

   // compare lanes, chained on the packing slot
   assign pos_chain[0] = fill;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      assign lane_en[i] = (req_stream.valid_lanes > count_type'(i));

      rvsc_lane u_lane (
         .lane_en      (lane_en[i]),
         .word         (lane_words[i]),
         .remove_value (remove_value_ff),
         .pos_in       (pos_chain[i]),
         .keep         (lane_keep[i]),
         .pos_out      (pos_chain[i+1])
      );
   end

   // merging stage with residual store
   rvsc_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .item_accept   (item_accept),
      .item_end      (req_stream.end_of_array),
      .lane_words    (lane_words),
      .lane_keep     (lane_keep),
      .lane_pos      (pos_chain[LANES-1:0]),
      .new_fill      (pos_chain[LANES]),
      .res_ready     (push_ready),
      .fill          (fill),
      .flush_pending (flush_pending),
      .res_valid     (res_valid),
      .res           (res)
   );

   // output buffer
   rvsc_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_valid),
      .push_data  (res),
      .push_ready (push_ready),
      .pop_valid  (rsp_stream.valid),
      .pop_ready  (rsp_stream.ready),
      .pop_data   (head)
   );

   assign rsp_stream.out_lane_0   = head.words[0];
   assign rsp_stream.out_lane_1   = head.words[1];
   assign rsp_stream.out_lane_2   = head.words[2];
   assign rsp_stream.out_lane_3   = head.words[3];
   assign rsp_stream.out_lane_4   = head.words[4];
   assign rsp_stream.out_lane_5   = head.words[5];
   assign rsp_stream.out_lane_6   = head.words[6];
   assign rsp_stream.out_lane_7   = head.words[7];
   assign rsp_stream.out_count    = head.count;
   assign rsp_stream.final_result = head.final_flag;
   assign rsp_stream.total_kept   = head.total;

endmodule

[hdl/rvsc_checker.sv]
// ----------------------------------------------------------------------------
// rvsc_checker
// Port-level checks on the response side of the compactor, bound to the top.
// ----------------------------------------------------------------------------
module rvsc_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input rvsc_pkg::word_type rsp_out_lane_7,
   input rvsc_pkg::count_type rsp_out_count,
   input logic               rsp_final_result,
   input rvsc_pkg::word_type rsp_total_kept
);
   import rvsc_pkg::*;

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // only the flush word may be partly filled
   a_full_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_result |-> rsp_out_count == count_type'(LANES))
      else $error("non-final word not full");

   // the last lane reads as zero when the word is not full
   a_tail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_count != count_type'(LANES)) |-> rsp_out_lane_7 == '0)
      else $error("unused lane not zero");

   // a full word means at least eight words of the array were kept so far
   a_total_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_result |-> rsp_total_kept >= word_type'(LANES))
      else $error("running total below packed words");

   // stalled word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_out_count) && $stable(rsp_total_kept))
      else $error("stalled response changed");

endmodule

bind remove_value_stream_compactor rvsc_checker u_rvsc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_stream.valid),
   .rsp_ready        (rsp_stream.ready),
   .rsp_out_lane_7   (rsp_stream.out_lane_7),
   .rsp_out_count    (rsp_stream.out_count),
   .rsp_final_result (rsp_stream.final_result),
   .rsp_total_kept   (rsp_stream.total_kept)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for remove_value_stream_compactor. Drives groups of
// eight lanes over the req channel, holds its own model of the residual
// store and running total, and compares every packed word on rsp against
// the oldest predicted word. Random stalls on both channels.
// ----------------------------------------------------------------------------
import rvsc_pkg::*;

// one input group as seen on req
typedef struct {
   word_type  lanes [LANES];
   count_type valid_lanes;
   logic      end_of_array;
} group_type;

// predicts packed words from accepted groups and checks arriving ones
class compaction_scoreboard;
   word_type    remove_value;
   word_type    residual_words [LANES];
   int unsigned residual_count;
   word_type    kept_total;
   result_type  expected_words [$];
   int unsigned errors;

   function new();
      remove_value   = '0;
      residual_count = 0;
      kept_total     = '0;
      errors         = 0;
   endfunction

   function int pending();
      return expected_words.size();
   endfunction

   // queue one word built from the first count entries of the pool
   function void queue_word(input word_type pool [2*LANES], input int unsigned count,
                            input logic last);
      result_type w;
      for (int j = 0; j < LANES; j++) begin
         w.words[j] = (j < count) ? pool[j] : '0;
      end
      w.count      = count_type'(count);
      w.final_flag = last;
      w.total      = kept_total;
      expected_words.push_back(w);
   endfunction

   // merge an accepted group into the residual store
   function void note_group(input group_type g);
      word_type        pool [2*LANES];
      int unsigned     fill;
      int unsigned     lanes_used;
      int unsigned     kept;
      longint unsigned sum;
      fill = residual_count;
      kept = 0;
      for (int i = 0; i < fill; i++) begin
         pool[i] = residual_words[i];
      end
      lanes_used = (g.valid_lanes > LANES) ? LANES : g.valid_lanes;
      for (int i = 0; i < lanes_used; i++) begin
         if (g.lanes[i] != remove_value) begin
            pool[fill] = g.lanes[i];
            fill++;
            kept++;
         end
      end
      // running total saturates at all ones
      sum = longint'(kept_total) + kept;
      kept_total = (sum > 64'hFFFF_FFFF) ? '1 : word_type'(sum);
      if (fill >= LANES) begin
         queue_word(pool, LANES, 1'b0);
         for (int i = 0; i < fill - LANES; i++) begin
            pool[i] = pool[i + LANES];
         end
         fill -= LANES;
      end
      if (g.end_of_array) begin
         queue_word(pool, fill, 1'b1);
         residual_count = 0;
         kept_total     = '0;
      end else begin
         for (int i = 0; i < fill; i++) begin
            residual_words[i] = pool[i];
         end
         residual_count = fill;
      end
   endfunction

   // compare an accepted word with the oldest prediction
   function void check_word(input result_type got);
      result_type want;
      if (expected_words.size() == 0) begin
         $error("unexpected result word, out_count %0d", got.count);
         errors++;
         return;
      end
      want = expected_words.pop_front();
      for (int j = 0; j < LANES; j++) begin
         if (got.words[j] !== want.words[j]) begin
            $error("out_lane_%0d: expected %h, actual %h", j, want.words[j], got.words[j]);
            errors++;
         end
      end
      if (got.count !== want.count) begin
         $error("out_count: expected %0d, actual %0d", want.count, got.count);
         errors++;
      end
      if (got.final_flag !== want.final_flag) begin
         $error("final_result: expected %0b, actual %0b", want.final_flag, got.final_flag);
         errors++;
      end
      if (got.total !== want.total) begin
         $error("total_kept: expected %0d, actual %0d", want.total, got.total);
         errors++;
      end
   endfunction

   function void check_drained();
      if (expected_words.size() != 0) begin
         $error("%0d result words never arrived", expected_words.size());
         errors++;
      end
   endfunction
endclass

module tb;

   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT   = 1000;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 100;

   logic     clock = 1'b0;
   logic     reset;
   logic     csr_wr_en;
   word_type csr_wr_data;

   rvsc_req_if req_bus ();
   rvsc_rsp_if rsp_bus ();

   compaction_scoreboard sb = new();

   logic req_up     = 1'b0;
   logic no_idle    = 1'b0;
   int   idle_cycles = 0;

   remove_value_stream_compactor dut (
      .clock       (clock),
      .reset       (reset),
      .req_stream  (req_bus),
      .rsp_stream  (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   always #5 clock = ~clock;

   // gap length: mostly none or short, a few long
   function automatic int pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // lane value biased towards the removed value and the extremes
   function automatic word_type random_word();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 25) return sb.remove_value;
      if (r < 35) begin
         case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0001;
            default: return 32'h0000_0000;
         endcase
      end
      return $urandom;
   endfunction

   function automatic group_type random_group(input count_type valid, input logic eoa);
      group_type g;
      for (int i = 0; i < LANES; i++) begin
         g.lanes[i] = random_word();
      end
      g.valid_lanes  = valid;
      g.end_of_array = eoa;
      return g;
   endfunction

   function automatic group_type extreme_group(input count_type valid, input logic eoa);
      group_type g;
      g.lanes[0] = 32'h8000_0000;
      g.lanes[1] = 32'h7FFF_FFFF;
      g.lanes[2] = 32'hFFFF_FFFF;
      g.lanes[3] = 32'h0000_0001;
      g.lanes[4] = 32'h0000_0000;
      g.lanes[5] = 32'h5555_5555;
      g.lanes[6] = 32'hAAAA_AAAA;
      g.lanes[7] = 32'hFFFF_FFFE;
      g.valid_lanes  = valid;
      g.end_of_array = eoa;
      return g;
   endfunction

   function automatic group_type pattern_group(input word_type base, input count_type valid,
                                               input logic eoa);
      group_type g;
      for (int i = 0; i < LANES; i++) begin
         g.lanes[i] = base + i;
      end
      g.valid_lanes  = valid;
      g.end_of_array = eoa;
      return g;
   endfunction

   // present one group and hold it until accepted
   task automatic send_group(input group_type g);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         if (req_up) begin
            req_bus.valid <= 1'b0;
            req_up = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.lane_0       <= g.lanes[0];
      req_bus.lane_1       <= g.lanes[1];
      req_bus.lane_2       <= g.lanes[2];
      req_bus.lane_3       <= g.lanes[3];
      req_bus.lane_4       <= g.lanes[4];
      req_bus.lane_5       <= g.lanes[5];
      req_bus.lane_6       <= g.lanes[6];
      req_bus.lane_7       <= g.lanes[7];
      req_bus.valid_lanes  <= g.valid_lanes;
      req_bus.end_of_array <= g.end_of_array;
      req_up = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic end_burst();
      if (req_up) begin
         req_bus.valid <= 1'b0;
         req_up = 1'b0;
      end
   endtask

   // wait until every predicted word is out and the pipe has settled
   task automatic wait_idle();
      end_burst();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_remove_value(input word_type value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.remove_value = value;
   endtask

   // one array of random length, normally terminated
   task automatic send_array(output int unsigned sent);
      int unsigned len;
      int unsigned r;
      count_type   valid;
      logic        eoa;
      len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      // a few arrays are left open and run into the next one
      eoa = ($urandom_range(0, 99) >= 5);
      for (int k = 0; k < len; k++) begin
         r = $urandom_range(0, 99);
         if (r < 70) valid = 4'd8;
         else if (r < 90) valid = count_type'($urandom_range(0, 7));
         else valid = count_type'($urandom_range(9, 15));
         send_group(random_group(valid, eoa && (k == len - 1)));
      end
      sent = len;
   endtask

   // sink side ready with random stalls
   initial begin : rsp_ready_drive
      int on_len;
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         on_len = $urandom_range(1, 16);
         rsp_bus.ready <= 1'b1;
         repeat (on_len) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // observe both channels at every edge
   always @(posedge clock) begin : monitor
      group_type  g;
      result_type w;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            g.lanes[0]     = req_bus.lane_0;
            g.lanes[1]     = req_bus.lane_1;
            g.lanes[2]     = req_bus.lane_2;
            g.lanes[3]     = req_bus.lane_3;
            g.lanes[4]     = req_bus.lane_4;
            g.lanes[5]     = req_bus.lane_5;
            g.lanes[6]     = req_bus.lane_6;
            g.lanes[7]     = req_bus.lane_7;
            g.valid_lanes  = req_bus.valid_lanes;
            g.end_of_array = req_bus.end_of_array;
            sb.note_group(g);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            w.words[0]   = rsp_bus.out_lane_0;
            w.words[1]   = rsp_bus.out_lane_1;
            w.words[2]   = rsp_bus.out_lane_2;
            w.words[3]   = rsp_bus.out_lane_3;
            w.words[4]   = rsp_bus.out_lane_4;
            w.words[5]   = rsp_bus.out_lane_5;
            w.words[6]   = rsp_bus.out_lane_6;
            w.words[7]   = rsp_bus.out_lane_7;
            w.count      = rsp_bus.out_count;
            w.final_flag = rsp_bus.final_result;
            w.total      = rsp_bus.total_kept;
            sb.check_word(w);
         end
      end
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // watchdog on cycles without any handshake
   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      int unsigned sent;
      int unsigned phase_count;
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_wr_data          <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.lane_0       <= '0;
      req_bus.lane_1       <= '0;
      req_bus.lane_2       <= '0;
      req_bus.lane_3       <= '0;
      req_bus.lane_4       <= '0;
      req_bus.lane_5       <= '0;
      req_bus.lane_6       <= '0;
      req_bus.lane_7       <= '0;
      req_bus.valid_lanes  <= '0;
      req_bus.end_of_array <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // removed value at its reset value of zero
      send_group(pattern_group(32'h0, 4'd8, 1'b0) );
      send_group(random_group(4'd8, 1'b0));
      send_group(extreme_group(4'd8, 1'b0));
      send_group(random_group(4'd3, 1'b0));
      // empty group, oversized count, then a count one above the lane total
      send_group(random_group(4'd0, 1'b0));
      send_group(random_group(4'd15, 1'b0));
      send_group(random_group(4'd9, 1'b1));
      // flush with nothing left over
      send_group(random_group(4'd0, 1'b1));
      // exactly one full word then an empty flush
      send_group(pattern_group(32'h10, 4'd8, 1'b1));
      // full word and a partial flush from the same group
      send_group(pattern_group(32'h20, 4'd5, 1'b0));
      send_group(pattern_group(32'h30, 4'd7, 1'b1));

      write_remove_value(32'h8000_0000);
      send_group(extreme_group(4'd8, 1'b0));
      send_group(pattern_group(32'h8000_0000, 4'd8, 1'b1));

      write_remove_value(32'h7FFF_FFFF);
      send_group(extreme_group(4'd8, 1'b0));
      send_group(random_group(4'd4, 1'b1));

      write_remove_value(32'hFFFF_FFFF);
      send_group(extreme_group(4'd8, 1'b1));
      send_group(random_group(4'd12, 1'b0));
      send_group(random_group(4'd8, 1'b1));

      // random phases, each with its own removed value
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 3)
            0: write_remove_value($urandom);
            1: write_remove_value((phase == 1) ? 32'h0 : 32'h8000_0000);
            default: write_remove_value($urandom_range(0, 3));
         endcase
         no_idle = (phase == 2);
         phase_count = 0;
         while (phase_count < PHASE_ITEMS) begin
            send_array(sent);
            phase_count += sent;
         end
         no_idle = 1'b0;
      end

      // drain
      end_burst();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.check_drained();
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
